>>> rtl/aging_bounded_priority_queue_defines.svh
// Assertion shorthands used by the checker file.
`ifndef AGING_BOUNDED_PRIORITY_QUEUE_DEFINES_SVH
`define AGING_BOUNDED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ABPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define ABPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/abpq_pkg.sv
`default_nettype none
package abpq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int ID_W      = 16;
	localparam int FUEL_W    = 12;
	localparam int IN_FUEL_W = 10;
	localparam int WAIT_W    = 16;
	localparam int SUM_W     = 32;
	localparam int LIMIT_W   = 4;

	localparam logic signed [FUEL_W-1:0] FUEL_MIN = {1'b1, {(FUEL_W-1){1'b0}}};
	localparam logic [WAIT_W-1:0]        WAIT_MAX = '1;

	localparam logic               ORDER_RST = 1'b1;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd6;

	localparam logic CFG_ORDER = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_PURGE  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_TICK   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic signed [FUEL_W-1:0] fuel;
		logic [WAIT_W-1:0]        waited;
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/aging_bounded_priority_queue.sv
// Bounded aging queue of up to DEPTH entries (id, signed fuel, wait count) kept as a
// circular buffer in a single-port-write, single-port-read memory. Requests arrive on
// the s_ stream (opcode: insert, purge expired heads, remove head, tick) and each yields
// exactly one result on the m_ stream; a finished result sits in an output register, so
// s_tready returns while it waits. One request is worked at a time; the insert and tick
// scans read one memory entry and then, where it changes, write it back before moving
// on to the next, and the next request is taken only after the result is loaded into
// the output register. Slot contents need no clearing after reset; only slots below
// the fill count are ever read. Configuration: index 0 order_by_fuel (reset 1),
// index 1 queue_limit (reset 6); write only while idle.
`default_nettype none
module aging_bounded_priority_queue #(
	parameter int DEPTH = abpq_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [1:0] opcode, [17:2] item_id, [27:18] item_fuel
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [1:0] status, [17:2] out_id, [33:18] out_waited,
	                                    // [37:34] purged_count, [41:38] occupancy,
	                                    // [73:42] wait_total
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data
);
	import abpq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_PUR_RD,
		S_PUR_CHK,
		S_REM_RD,
		S_REM_POP,
		S_TCK_RD,
		S_TCK_WR,
		S_FIN
	} state_t;

	// logical index k from the head to a physical slot, wrapping at DEPTH
	function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(k);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return AW'(s);
	endfunction

	state_t               state_q;
	logic                 order_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        fill_q;
	logic [SUM_W-1:0]     wait_sum_q;

	// request being worked
	logic [ID_W-1:0]      id_q;
	logic [IN_FUEL_W-1:0] fuel_q;
	logic [CW-1:0]        idx_q;
	logic                 found_q;
	entry_t               carry_q;

	// result being built
	status_t              status_q;
	logic [ID_W-1:0]      rid_q;
	logic [WAIT_W-1:0]    rwait_q;
	logic [CW-1:0]        purged_q;

	// output register
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ID_W-1:0]      out_id_q;
	logic [WAIT_W-1:0]    out_wait_q;
	logic [3:0]           out_purged_q;
	logic [3:0]           out_occ_q;
	logic [SUM_W-1:0]     out_total_q;

	// memory port
	logic                 wr_en;
	logic [AW-1:0]        slot_addr;
	entry_t               wr_data;
	entry_t               rd_data;

	entry_t               new_entry;
	entry_t               aged_entry;
	logic signed [FUEL_W-1:0] new_fuel;
	logic                 rd_greater;
	logic                 full;
	logic [AW-1:0]        head_next;
	logic [SUM_W:0]       sum_ext;
	opcode_t              in_op;
	status_t              in_status;
	logic                 out_load;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'd0, out_total_q, out_occ_q, out_purged_q, out_wait_q, out_id_q,
	                    out_status_q};

	assign in_op     = opcode_t'(s_tdata[1:0]);
	assign new_fuel  = {{(FUEL_W-IN_FUEL_W){1'b0}}, fuel_q};
	assign new_entry = '{id: id_q, fuel: new_fuel, waited: '0};
	assign rd_greater = (rd_data.fuel > new_fuel);
	assign head_next = addr_add(head_q, CW'(1));
	assign sum_ext   = {1'b0, wait_sum_q} + (SUM_W+1)'(rd_data.waited);
	assign slot_addr = addr_add(head_q, idx_q);

	// refuse at min(queue_limit, DEPTH)
	assign full = (LW'(fill_q) >= LW'(limit_q)) || (fill_q >= CW'(DEPTH));

	// status known at accept: refused insert and empty remove finish at once
	assign in_status = (in_op == OP_INSERT && full) ? ST_FULL :
	                   (in_op == OP_REMOVE && fill_q == '0) ? ST_EMPTY : ST_DONE;

	// load the output register once the finished result finds it free
	assign out_load = (state_q == S_FIN) && (!out_valid_q || m_tready);

	// age one entry: fuel down to its floor, wait up to its ceiling
	always_comb begin
		aged_entry = rd_data;
		if (rd_data.fuel != FUEL_MIN) begin
			aged_entry.fuel = rd_data.fuel - FUEL_W'(1);
		end
		if (rd_data.waited != WAIT_MAX) begin
			aged_entry.waited = rd_data.waited + WAIT_W'(1);
		end
	end

	// write side of the memory; reads always address the current logical index
	always_comb begin
		wr_en   = 1'b0;
		wr_data = new_entry;
		unique case (state_q)
			S_INS_RD: begin
				// reached the tail: place whatever is still pending
				if (idx_q == fill_q) begin
					wr_en   = 1'b1;
					wr_data = found_q ? carry_q : new_entry;
				end
			end
			S_INS_CMP: begin
				if (found_q) begin
					wr_en   = 1'b1;
					wr_data = carry_q;
				end else if (order_q && rd_greater) begin
					wr_en   = 1'b1;
					wr_data = new_entry;
				end
			end
			S_TCK_WR: begin
				wr_en   = 1'b1;
				wr_data = aged_entry;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	abpq_slot_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(slot_addr),
		.wr_data(wr_data),
		.rd_addr(slot_addr),
		.rd_data(rd_data)
	);

	// sequencer: insert and tick scans work one entry per read/write pair; purge and remove only read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			order_q     <= ORDER_RST;
			limit_q     <= LIMIT_RST;
			head_q      <= '0;
			fill_q      <= '0;
			wait_sum_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ORDER: order_q <= cfg_data[0];
					CFG_LIMIT: limit_q <= cfg_data;
				endcase
			end

			// raise valid on a new result, drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						id_q     <= s_tdata[17:2];
						fuel_q   <= s_tdata[27:18];
						// FIFO mode skips the scan and goes to the tail
						idx_q    <= (in_op == OP_INSERT && !order_q) ? fill_q : '0;
						found_q  <= 1'b0;
						status_q <= in_status;
						rid_q    <= '0;
						rwait_q  <= '0;
						purged_q <= '0;
						unique case (in_op)
							OP_INSERT: state_q <= full ? S_FIN : S_INS_RD;
							OP_PURGE:  state_q <= S_PUR_RD;
							OP_REMOVE: state_q <= (fill_q == '0) ? S_FIN : S_REM_RD;
							OP_TICK:   state_q <= S_TCK_RD;
						endcase
					end
				end
				S_INS_RD: begin
					if (idx_q == fill_q) begin
						fill_q  <= fill_q + CW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					// once placed, ripple the displaced entries one slot toward the tail
					if (found_q) begin
						carry_q <= rd_data;
					end else if (order_q && rd_greater) begin
						found_q <= 1'b1;
						carry_q <= rd_data;
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_INS_RD;
				end
				S_PUR_RD: begin
					state_q <= (fill_q == '0) ? S_FIN : S_PUR_CHK;
				end
				S_PUR_CHK: begin
					if (rd_data.fuel < 0) begin
						head_q   <= head_next;
						fill_q   <= fill_q - CW'(1);
						purged_q <= purged_q + CW'(1);
						state_q  <= S_PUR_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_REM_RD: begin
					state_q <= S_REM_POP;
				end
				S_REM_POP: begin
					rid_q      <= rd_data.id;
					rwait_q    <= rd_data.waited;
					wait_sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
					head_q     <= head_next;
					fill_q     <= fill_q - CW'(1);
					state_q    <= S_FIN;
				end
				S_TCK_RD: begin
					state_q <= (idx_q == fill_q) ? S_FIN : S_TCK_WR;
				end
				S_TCK_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_TCK_RD;
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_load) begin
						out_status_q <= status_q;
						out_id_q     <= rid_q;
						out_wait_q   <= rwait_q;
						out_purged_q <= 4'(purged_q);
						out_occ_q    <= 4'(fill_q);
						out_total_q  <= wait_sum_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/abpq_slot_ram.sv
`default_nettype none
module abpq_slot_ram #(
	parameter int DEPTH = abpq_pkg::DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire abpq_pkg::entry_t                       wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output abpq_pkg::entry_t                            rd_data
);
	abpq_pkg::entry_t mem_q [DEPTH];

	// one write port, one read port with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

>>> rtl/abpq_checker.sv
`default_nettype none
`include "aging_bounded_priority_queue_defines.svh"
module abpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata
);
	import abpq_pkg::*;

	// one request at a time: ready is low in the cycle after an accept
	`ABPQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

	// a stalled result holds its value
	`ABPQ_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// a refused insert reports no removal and no purge
	`ABPQ_ASSERT_NOW(a_full_fields, m_tvalid && (m_tdata[1:0] == ST_FULL), m_tdata[37:2] == 36'd0, "refused insert carries data")

	// an empty remove leaves the queue empty
	`ABPQ_ASSERT_NOW(a_empty_occ, m_tvalid && (m_tdata[1:0] == ST_EMPTY), (m_tdata[41:38] == 4'd0) && (m_tdata[37:2] == 36'd0), "empty remove with entries")

endmodule

bind aging_bounded_priority_queue abpq_checker u_abpq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
